// ----- design/video_register_port_macros.svh -----
// Assertion helpers for the port's execute module (vrp_exec).
`ifndef VIDEO_REGISTER_PORT_MACROS_SVH
`define VIDEO_REGISTER_PORT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define VRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define VRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define VRP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/vrp_pkg.sv -----
package vrp_pkg;

	// bus commands
	localparam logic [2:0] CMD_CTRL   = 3'd0;
	localparam logic [2:0] CMD_MASK   = 3'd1;
	localparam logic [2:0] CMD_SPRITE = 3'd2;
	localparam logic [2:0] CMD_SCROLL = 3'd3;
	localparam logic [2:0] CMD_ADDR   = 3'd4;
	localparam logic [2:0] CMD_DATA   = 3'd5;
	localparam logic [2:0] CMD_STATUS = 3'd6;
	localparam logic [2:0] CMD_VBLANK = 3'd7;

	// data write outcomes
	localparam logic [2:0] OUT_NONE      = 3'd0;
	localparam logic [2:0] OUT_NAMETABLE = 3'd1;
	localparam logic [2:0] OUT_PALETTE   = 3'd2;
	localparam logic [2:0] OUT_ROM       = 3'd3;
	localparam logic [2:0] OUT_UNSUP     = 3'd4;

	localparam logic [15:0] NT_BASE     = 16'h2000;
	localparam logic [15:0] NT_END      = 16'h3000;
	localparam logic [15:0] PAL_BASE    = 16'h3F00;
	localparam logic [15:0] PAL_END     = 16'h3F20;
	localparam logic [15:0] INC_ROW     = 16'd32;
	localparam logic [15:0] INC_ONE     = 16'd1;
	localparam int          CTRL_INC_BIT = 2;
	localparam int          CTRL_NMI_BIT = 7;
	localparam int          STATUS_VBL_BIT = 7;

	localparam int PAL_BYTES = 32;
	localparam int PAL_AW    = 5;
	localparam int IDX_W     = 11;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] write_value;
	} req_t;

	typedef struct packed {
		logic [7:0]       read_value;
		logic             nmi;
		logic [2:0]       outcome;
		logic [IDX_W-1:0] store_index;
		logic [15:0]      video_address;
		logic [7:0]       scroll_x_value;
		logic [7:0]       scroll_y_value;
	} rsp_t;

	typedef struct packed {
		logic             nt_en;
		logic             pal_en;
		logic [IDX_W-1:0] index;
		logic [7:0]       data;
	} store_wr_t;

endpackage

// ----- design/vrp_ram.sv -----
module vrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- design/vrp_exec.sv -----
`include "video_register_port_macros.svh"

module vrp_exec #(
	parameter int NT_BYTES = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  vrp_pkg::req_t       item,
	output vrp_pkg::rsp_t       result,
	output vrp_pkg::store_wr_t  store_wr
);

	localparam int NT_AW = $clog2(NT_BYTES);

	logic [7:0]  control_q;
	logic [7:0]  mask_q;
	logic [7:0]  sprite_addr_q;
	logic [7:0]  scroll_x_q;
	logic [7:0]  scroll_y_q;
	logic        scroll_tog_q;
	logic        addr_tog_q;
	logic [15:0] address_q;
	logic        vblank_q;

	logic [7:0]  control_d;
	logic [7:0]  mask_d;
	logic [7:0]  sprite_addr_d;
	logic [7:0]  scroll_x_d;
	logic [7:0]  scroll_y_d;
	logic        scroll_tog_d;
	logic        addr_tog_d;
	logic [15:0] address_d;
	logic        vblank_d;
	logic [15:0] step;
	logic        in_rom;
	logic        in_nt;
	logic        in_pal;

	assign step   = control_q[vrp_pkg::CTRL_INC_BIT] ? vrp_pkg::INC_ROW : vrp_pkg::INC_ONE;
	assign in_rom = address_q < vrp_pkg::NT_BASE;
	assign in_nt  = !in_rom && (address_q < vrp_pkg::NT_END);
	assign in_pal = (address_q >= vrp_pkg::PAL_BASE) && (address_q < vrp_pkg::PAL_END);

	always_comb begin
		control_d     = control_q;
		mask_d        = mask_q;
		sprite_addr_d = sprite_addr_q;
		scroll_x_d    = scroll_x_q;
		scroll_y_d    = scroll_y_q;
		scroll_tog_d  = scroll_tog_q;
		addr_tog_d    = addr_tog_q;
		address_d     = address_q;
		vblank_d      = vblank_q;
		result        = '0;
		store_wr      = '0;
		store_wr.data = item.write_value;
		case (item.command)
			vrp_pkg::CMD_CTRL: begin
				control_d = item.write_value;
			end
			vrp_pkg::CMD_MASK: begin
				mask_d = item.write_value;
			end
			vrp_pkg::CMD_SPRITE: begin
				sprite_addr_d = item.write_value;
			end
			vrp_pkg::CMD_SCROLL: begin
				if (!scroll_tog_q) begin
					scroll_x_d = item.write_value;
				end else begin
					scroll_y_d = item.write_value;
				end
				scroll_tog_d = !scroll_tog_q;
			end
			vrp_pkg::CMD_ADDR: begin
				// high byte first, then low byte
				if (!addr_tog_q) begin
					address_d = {item.write_value, address_q[7:0]};
				end else begin
					address_d = {address_q[15:8], item.write_value};
				end
				addr_tog_d = !addr_tog_q;
			end
			vrp_pkg::CMD_DATA: begin
				if (in_rom) begin
					result.outcome = vrp_pkg::OUT_ROM;
				end else if (in_nt) begin
					result.outcome    = vrp_pkg::OUT_NAMETABLE;
					store_wr.nt_en    = 1'b1;
					store_wr.index    = vrp_pkg::IDX_W'(address_q[NT_AW-1:0]);
				end else if (in_pal) begin
					result.outcome    = vrp_pkg::OUT_PALETTE;
					store_wr.pal_en   = 1'b1;
					store_wr.index    = vrp_pkg::IDX_W'(address_q[vrp_pkg::PAL_AW-1:0]);
				end else begin
					result.outcome = vrp_pkg::OUT_UNSUP;
				end
				result.store_index = store_wr.index;
				address_d = address_q + step;
			end
			vrp_pkg::CMD_STATUS: begin
				// sample the flag before clearing it
				result.read_value[vrp_pkg::STATUS_VBL_BIT] = vblank_q;
				scroll_tog_d = 1'b0;
				addr_tog_d   = 1'b0;
				vblank_d     = 1'b0;
			end
			default: begin
				vblank_d   = 1'b1;
				result.nmi = control_q[vrp_pkg::CTRL_NMI_BIT];
			end
		endcase
		result.video_address  = address_d;
		result.scroll_x_value = scroll_x_d;
		result.scroll_y_value = scroll_y_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q     <= '0;
			mask_q        <= '0;
			sprite_addr_q <= '0;
			scroll_x_q    <= '0;
			scroll_y_q    <= '0;
			scroll_tog_q  <= 1'b0;
			addr_tog_q    <= 1'b0;
			address_q     <= '0;
			vblank_q      <= 1'b0;
		end else if (advance) begin
			control_q     <= control_d;
			mask_q        <= mask_d;
			sprite_addr_q <= sprite_addr_d;
			scroll_x_q    <= scroll_x_d;
			scroll_y_q    <= scroll_y_d;
			scroll_tog_q  <= scroll_tog_d;
			addr_tog_q    <= addr_tog_d;
			address_q     <= address_d;
			vblank_q      <= vblank_d;
		end
	end

	`VRP_ASSERT_NEXT(a_status_clears, clk, arst_n,
		advance && item.command == vrp_pkg::CMD_STATUS,
		!vblank_q && !scroll_tog_q && !addr_tog_q)
	`VRP_ASSERT_NEXT(a_vblank_sets, clk, arst_n,
		advance && item.command == vrp_pkg::CMD_VBLANK, vblank_q)
	`VRP_ASSERT_IMPL(a_store_only_on_data, clk, arst_n,
		store_wr.nt_en || store_wr.pal_en, item.command == vrp_pkg::CMD_DATA)
	`VRP_ASSERT_NEXT(a_data_advances_addr, clk, arst_n,
		advance && item.command == vrp_pkg::CMD_DATA,
		address_q == $past(address_q + step))

endmodule

// ----- design/video_register_port.sv -----
// CPU-side register port of the picture unit. One bus access or vblank event is taken
// per cycle on req while req_ready is high, and its result reaches rsp through the
// input register, then the result register; the register file update and the single
// store write happen together as the item moves from the input register into the result
// register. Nametable and palette contents come up undefined after reset and are never read.

module video_register_port #(
	parameter int NAMETABLE_BYTES = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  vrp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output vrp_pkg::rsp_t rsp
);

	localparam int NT_AW = $clog2(NAMETABLE_BYTES);

	logic               valid_s1;
	vrp_pkg::req_t      item_s1;
	logic               valid_s2;
	vrp_pkg::rsp_t      rsp_s2;
	logic               advance;
	vrp_pkg::rsp_t      result;
	vrp_pkg::store_wr_t store_wr;

	// move the held item on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	vrp_exec #(
		.NT_BYTES(NAMETABLE_BYTES)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.result   (result),
		.store_wr (store_wr)
	);

	vrp_ram #(
		.WIDTH(8),
		.DEPTH(NAMETABLE_BYTES)
	) u_nametable (
		.clk   (clk),
		.we    (advance && store_wr.nt_en),
		.addr  (store_wr.index[NT_AW-1:0]),
		.wdata (store_wr.data),
		.rdata ()
	);

	vrp_ram #(
		.WIDTH(8),
		.DEPTH(vrp_pkg::PAL_BYTES)
	) u_palette (
		.clk   (clk),
		.we    (advance && store_wr.pal_en),
		.addr  (store_wr.index[vrp_pkg::PAL_AW-1:0]),
		.wdata (store_wr.data),
		.rdata ()
	);

endmodule
